// ===== sv/ftl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table package
// Table sizing, derived widths and the request/response types.
// ----------------------------------------------------------------------------
package ftl_pkg;

  localparam int unsigned TABLE_DEPTH = 16;  // 1 .. 16
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PTR_W  = CNT_W + 1;          // room for ptr + 2
  localparam int unsigned WIDE_W = (PTR_W > 5) ? PTR_W : 5;
  localparam int unsigned KEY_W  = 64;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_REMOVE = 1'b1
  } ftl_mode_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] remote_addr;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] flow_tag;
    logic [3:0]  entry_index;
  } ftl_req_t;

  typedef struct packed {
    logic [3:0] found_index;
    logic       created;
    logic       fault;
    logic [4:0] occupancy;
  } ftl_rsp_t;

endpackage

// ===== sv/flow_table_lookup_insert_remove_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table: exact-match lookup/insert and remove by index
// Lookup scans the entries in use in order and appends the key on a full miss
//   unless the table is full. Remove answers from idle on a fault or for the
//   last entry, else it shifts the entries above the index down by one.
// Throughput: one request at a time; the next one is taken in the cycle the
//   result is strobed. Set by the single read port of the key RAMs, which
//   visits one entry per cycle.
// Reset: asynchronous, clears the entry count and control; key RAMs keep
//   garbage until written. Results are strobed for one cycle, no stall.
// ----------------------------------------------------------------------------
module flow_table_lookup_insert_remove_top
  import ftl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ftl_req_t req_i,
  output logic     done_o,
  output ftl_rsp_t rsp_o
);

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SCAN_LOAD = 5'b00010,  // issue read of entry 0
    ST_SCAN_CMP  = 5'b00100,  // compare entry ptr, prefetch ptr+1
    ST_RM_LOAD   = 5'b01000,  // issue read of entry ptr+1
    ST_RM_MOVE   = 5'b10000   // write entry ptr from ptr+1, prefetch ptr+2
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  ftl_req_t          key_q, key_d;
  ftl_rsp_t          rsp_q, rsp_d;
  logic              done_q, done_d;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [KEY_W-1:0]  pk_wdata, ak_wdata;
  logic [KEY_W-1:0]  pk_rdata, ak_rdata;

  // Key words as stored: ports+tag in one RAM, addresses in the other
  logic [KEY_W-1:0]  key_pk, key_ak;
  assign key_pk = {key_q.src_port, key_q.dst_port, key_q.peer_port, key_q.flow_tag};
  assign key_ak = {key_q.remote_addr, key_q.peer_addr};

  // Shared compare unit: one stored entry against the latched key
  logic hit;
  assign hit = (pk_rdata == key_pk) && (ak_rdata == key_ak);

  // Pointer arithmetic carried one bit wider than the count
  logic [PTR_W-1:0]  ptr_ext, count_ext;
  logic [WIDE_W-1:0] req_idx_w, count_w;
  assign ptr_ext   = PTR_W'(ptr_q);
  assign count_ext = PTR_W'(count_q);
  assign req_idx_w = WIDE_W'(req_i.entry_index);
  assign count_w   = WIDE_W'(count_q);

  logic full;
  assign full = (count_q == CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    key_d     = key_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_raddr = ptr_q;
    pk_wdata  = pk_rdata;
    ak_wdata  = ak_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          key_d = req_i;
          if (req_i.mode == MODE_LOOKUP) begin
            state_d = ST_SCAN_LOAD;
          end else if (req_idx_w >= count_w) begin
            // out-of-range remove: report and leave the table alone
            rsp_d  = '{found_index: 4'd0, created: 1'b0, fault: 1'b1,
                       occupancy: 5'(count_q)};
            done_d = 1'b1;
          end else if (req_idx_w + WIDE_W'(1) == count_w) begin
            // removing the tail entry needs no data movement
            count_d = count_q - CNT_W'(1);
            rsp_d   = '{found_index: 4'd0, created: 1'b0, fault: 1'b0,
                        occupancy: 5'(count_q - CNT_W'(1))};
            done_d  = 1'b1;
          end else begin
            ptr_d   = IDX_W'(req_idx_w);
            state_d = ST_RM_LOAD;
          end
        end
      end

      ST_SCAN_LOAD: begin
        ram_raddr = '0;
        ptr_d     = '0;
        if (count_q == '0) begin
          // empty table: append at entry 0
          ram_we    = 1'b1;
          ram_waddr = '0;
          pk_wdata  = key_pk;
          ak_wdata  = key_ak;
          count_d   = CNT_W'(1);
          rsp_d     = '{found_index: 4'd0, created: 1'b1, fault: 1'b0,
                        occupancy: 5'd1};
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        ram_raddr = IDX_W'(ptr_ext + PTR_W'(1));
        if (hit) begin
          rsp_d   = '{found_index: 4'(ptr_q), created: 1'b0, fault: 1'b0,
                      occupancy: 5'(count_q)};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (ptr_ext + PTR_W'(1) == count_ext) begin
          // missed every entry in use
          if (full) begin
            rsp_d = '{found_index: 4'd0, created: 1'b0, fault: 1'b1,
                      occupancy: 5'(count_q)};
          end else begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(count_q);
            pk_wdata  = key_pk;
            ak_wdata  = key_ak;
            count_d   = count_q + CNT_W'(1);
            rsp_d     = '{found_index: 4'(count_q), created: 1'b1, fault: 1'b0,
                          occupancy: 5'(count_q + CNT_W'(1))};
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end

      ST_RM_LOAD: begin
        ram_raddr = IDX_W'(ptr_ext + PTR_W'(1));
        state_d   = ST_RM_MOVE;
      end

      ST_RM_MOVE: begin
        // read data holds entry ptr+1; it moves down into ptr
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_raddr = IDX_W'(ptr_ext + PTR_W'(2));
        if (ptr_ext + PTR_W'(2) >= count_ext) begin
          count_d = count_q - CNT_W'(1);
          rsp_d   = '{found_index: 4'd0, created: 1'b0, fault: 1'b0,
                      occupancy: 5'(count_q - CNT_W'(1))};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  ftl_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_port_keys (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(pk_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(pk_rdata)
  );

  ftl_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_addr_keys (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ak_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ak_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/ftl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ftl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/ftl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table checker
// Port-level properties of the flow table, bound to the top level.
// ----------------------------------------------------------------------------
module ftl_checker
  import ftl_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input ftl_req_t req_i,
  input logic     done_o,
  input ftl_rsp_t rsp_o
);

  // a result only shows once the sequencer is back in idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // a new entry lands right at the old tail
  a_created_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.created) |->
      (!rsp_o.fault && rsp_o.found_index == 4'(rsp_o.occupancy - 5'd1)))
    else $error("created entry index does not match occupancy");

  // a fault reports index zero and creates nothing
  a_fault_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.fault) |-> (rsp_o.found_index == 4'd0 && !rsp_o.created))
    else $error("fault result carries index or created flag");

  // occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((TABLE_DEPTH >= 32) || (rsp_o.occupancy <= 5'(TABLE_DEPTH))))
    else $error("occupancy above table depth");

  // an accepted request always raises busy or answers right away
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither started nor answered");

endmodule

bind flow_table_lookup_insert_remove_top ftl_checker u_ftl_checker (.*);
